@@ rtl/lsbpd_pkg.sv @@
// Package for the log spectrum bar block: widths, register indexes, bar edge table
// and the bin-to-bar lookup function.
// No dependencies.
`default_nettype none

package lsbpd_pkg;

    localparam int FFT_POINTS  = 512;
    localparam int BIN_INDEX_W = $clog2(FFT_POINTS);
    localparam int GAIN_W      = 32;
    localparam int HEIGHT_W    = 7;
    localparam int BAR_W       = 5;
    localparam int MAX_BARS    = 32;
    localparam int TERM_W      = HEIGHT_W + 1;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam logic [TERM_W-1:0] TERM_SAT = TERM_W'(1 << HEIGHT_W);

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CEILING = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RESET    = 32'd768;
    localparam logic [HEIGHT_W-1:0] DECAY_RESET   = 7'd6;
    localparam logic [HEIGHT_W-1:0] CEILING_RESET = 7'd127;

    localparam logic [BIN_INDEX_W-1:0] BAR_EDGE [MAX_BARS+1] = '{
        9'd1,   9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,
        9'd10,  9'd11,  9'd13,  9'd15,  9'd17,  9'd19,  9'd21,  9'd23,
        9'd25,  9'd29,  9'd33,  9'd37,  9'd40,  9'd44,  9'd48,  9'd54,
        9'd61,  9'd67,  9'd74,  9'd90,  9'd101, 9'd137, 9'd158, 9'd187,
        9'd255
    };

    typedef struct packed {
        logic             hit;
        logic             close;
        logic [BAR_W-1:0] bar;
    } bin_map_t;

    typedef struct packed {
        logic             upd;
        logic             close;
        logic [BAR_W-1:0] bar;
    } bar_cmd_t;

    function automatic bin_map_t bin_lookup(logic [BIN_INDEX_W-1:0] idx,
                                            logic [BAR_W:0] bar_count);
        bin_map_t m;
        m = '0;
        for (int b = 0; b < MAX_BARS; b++) begin
            if (b < int'(bar_count) && idx >= BAR_EDGE[b] && idx < BAR_EDGE[b+1]) begin
                m.hit   = 1'b1;
                m.bar   = BAR_W'(b);
                m.close = (idx == BAR_EDGE[b+1] - 9'd1);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/log_spectrum_bar_peak_decay_top.sv @@
// Path: an accepted beat starts lsbpd_mag (S_RUN, one root bit per cycle, then S_TAIL),
// whose done lets lsbpd_bar update; a closing bin, once the result register is free,
// loads it. A mapped bin holds s_tready low until that update; unmapped bins do not.
// The result register lets the next beat in while a result waits on m_tready.
// Reset: synchronous, active-low aresetn; clears control, bar sum, all peaks at once
// and loads register defaults (gain 768, decay step 6, ceiling 127); no clearing pass.
`default_nettype none

module log_spectrum_bar_peak_decay_top import lsbpd_pkg::*; #(
    parameter int BAR_COUNT  = 32,
    parameter int POWER_BITS = 48,
    localparam int S_TDATA_W = ((BIN_INDEX_W + POWER_BITS + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,  // bin_index, bin_power
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,  // bar_number, bar_height
    output logic                        m_tlast
);

    localparam int PAD_W = M_TDATA_W - BAR_W - HEIGHT_W;

    typedef enum logic {S_IDLE, S_MAG} state_t;

    state_t                state_reg;
    bin_map_t              map_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [HEIGHT_W-1:0]   decay_reg;
    logic [HEIGHT_W-1:0]   ceiling_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  accept;
    bin_map_t              map;
    logic                  mag_done;
    logic [TERM_W-1:0]     term;
    bar_cmd_t              bar_cmd;
    logic [HEIGHT_W-1:0]   bar_height;

    always_comb begin
        s_tready    = (state_reg == S_IDLE);
        accept      = s_tvalid & s_tready;
        map         = bin_lookup(s_tdata[BIN_INDEX_W-1:0], (BAR_W+1)'(BAR_COUNT));
        bar_cmd.upd = (state_reg == S_MAG) && mag_done
                      && (!map_reg.close || !m_tvalid_reg || m_tready);
        bar_cmd.close = map_reg.close;
        bar_cmd.bar   = map_reg.bar;
    end

    lsbpd_mag #(
        .POWER_BITS (POWER_BITS)
    ) u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && map.hit),
        .power   (s_tdata[BIN_INDEX_W +: POWER_BITS]),
        .gain    (gain_reg),
        .done    (mag_done),
        .term    (term)
    );

    lsbpd_bar #(
        .BAR_COUNT (BAR_COUNT)
    ) u_bar (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (bar_cmd),
        .term       (term),
        .ceiling    (ceiling_reg),
        .decay_step (decay_reg),
        .height     (bar_height)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            gain_reg     <= GAIN_RESET;
            decay_reg    <= DECAY_RESET;
            ceiling_reg  <= CEILING_RESET;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_GAIN:    gain_reg    <= cfg_wdata;
                    REG_DECAY:   decay_reg   <= cfg_wdata[HEIGHT_W-1:0];
                    REG_CEILING: ceiling_reg <= cfg_wdata[HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        map_reg <= map;
                        if (map.hit) begin
                            state_reg <= S_MAG;
                        end
                    end
                end
                S_MAG: begin
                    if (bar_cmd.upd) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (bar_cmd.upd && bar_cmd.close) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{PAD_W{1'b0}}, bar_height, bar_cmd.bar};
                m_tlast_reg  <= (bar_cmd.bar == BAR_W'(BAR_COUNT - 1));
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_result_from_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_MAG && mag_done))
        else $error("result beat raised without a finished magnitude");

    a_hit_starts_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && map.hit |=> state_reg == S_MAG && !mag_done)
        else $error("mapped bin did not start the magnitude unit");

    a_last_bar_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tdata_reg[BAR_W-1:0] == BAR_W'(BAR_COUNT - 1))
        else $error("tlast on a bar other than the final one");
`endif

endmodule

`default_nettype wire

@@ rtl/lsbpd_mag.sv @@
// Bin magnitude unit: digit-serial square root, one root bit per cycle, with the
// gain product accumulated MSB first as the root bits come out. Uses lsbpd_pkg.
`default_nettype none

module lsbpd_mag import lsbpd_pkg::*; #(
    parameter int POWER_BITS = 48
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [POWER_BITS-1:0] power,
    input  wire logic [GAIN_W-1:0]     gain,
    output logic                       done,
    output logic [TERM_W-1:0]          term
);

    localparam int RW = (POWER_BITS + 1) / 2;
    localparam int CW = $clog2(RW);
    localparam int AW = GAIN_W - 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_TAIL} state_t;

    state_t             state_reg;
    logic [2*RW-1:0]    rad_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [CW-1:0]      cnt_reg;
    logic               bit_reg;
    logic               bit_vld_reg;
    logic [AW-1:0]      acc_reg;
    logic               sat_reg;
    logic               done_reg;

    logic [RW+3:0]      minuend;
    logic [RW+3:0]      subtr;
    logic [RW+4:0]      diff;
    logic               fits;
    logic [RW+1:0]      rem_next;
    logic [RW-1:0]      root_next;
    logic [GAIN_W:0]    prod;
    logic [AW-1:0]      acc_next;
    logic               sat_next;

    always_comb begin
        minuend   = {rem_reg, rad_reg[2*RW-1 -: 2]};
        subtr     = {2'b00, root_reg, 2'b01};
        diff      = {1'b0, minuend} - {1'b0, subtr};
        fits      = ~diff[RW+4];
        rem_next  = fits ? diff[RW+1:0] : minuend[RW+1:0];
        root_next = {root_reg[RW-2:0], fits};
        prod      = {1'b0, acc_reg, 1'b0} + {1'b0, (bit_reg ? gain : {GAIN_W{1'b0}})};
        acc_next  = prod[AW-1:0];
        sat_next  = sat_reg | (prod[GAIN_W:AW] != 2'b00);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bit_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            bit_vld_reg <= (state_reg == S_RUN);
            if (bit_vld_reg) begin
                acc_reg <= acc_next;
                sat_reg <= sat_next;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        rad_reg   <= (2*RW)'(power);
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        sat_reg   <= 1'b0;
                        done_reg  <= 1'b0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
                    bit_reg  <= fits;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(RW - 1)) begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign term = sat_reg ? TERM_SAT : {1'b0, acc_reg[AW-1 -: HEIGHT_W]};

`ifndef SYNTHESIS
    a_no_done_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !done_reg)
        else $error("magnitude flagged done while still iterating");

    a_tail_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TAIL |=> done_reg && state_reg == S_IDLE)
        else $error("magnitude tail did not finish the item");
`endif

endmodule

`default_nettype wire

@@ rtl/lsbpd_bar.sv @@
// Bar accumulator: saturating running sum of the open bar and the per-bar peak
// store with decay. Uses lsbpd_pkg.
`default_nettype none

module lsbpd_bar import lsbpd_pkg::*; #(
    parameter int BAR_COUNT = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bar_cmd_t            cmd,
    input  wire logic [TERM_W-1:0]   term,
    input  wire logic [HEIGHT_W-1:0] ceiling,
    input  wire logic [HEIGHT_W-1:0] decay_step,
    output logic [HEIGHT_W-1:0]      height
);

    localparam int PW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

    logic [HEIGHT_W-1:0] sum_reg;
    logic [HEIGHT_W-1:0] peak_reg [BAR_COUNT];

    logic [PW-1:0]       sel;
    logic [HEIGHT_W+1:0] total;
    logic [HEIGHT_W-1:0] sum_sat;
    logic [HEIGHT_W-1:0] peak_cur;

    always_comb begin
        sel      = cmd.bar[PW-1:0];
        total    = {2'b00, sum_reg} + {1'b0, term};
        sum_sat  = (total > {2'b00, ceiling}) ? ceiling : total[HEIGHT_W-1:0];
        peak_cur = peak_reg[sel];
        if (sum_sat > peak_cur) begin
            height = sum_sat;
        end else if (peak_cur > decay_step) begin
            height = peak_cur - decay_step;
        end else begin
            height = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < BAR_COUNT; i++) begin
                peak_reg[i] <= '0;
            end
        end else if (cmd.upd) begin
            if (cmd.close) begin
                sum_reg       <= '0;
                peak_reg[sel] <= height;
            end else begin
                sum_reg <= sum_sat;
            end
        end
    end

endmodule

`default_nettype wire
